/* rtl/ise_pkg.sv */
`default_nettype none

package ise_pkg;

  // request kinds carried in tuser
  typedef enum logic [2:0] {
    MODE_SELECT   = 3'd0,
    MODE_DESELECT = 3'd1,
    MODE_UNUSED   = 3'd2,
    MODE_QUERY    = 3'd3,
    MODE_INSERT   = 3'd4,
    MODE_REMOVE   = 3'd5,
    MODE_COUNT    = 3'd6,
    MODE_CLEAR    = 3'd7
  } mode_e;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // per-cycle control shared by every cell of the chain
  typedef struct packed {
    logic pop;   // whole chain moves one cell toward cell 0
    logic push;  // write the pushed interval at the write pointer
  } cell_ctrl_t;

  localparam int unsigned FieldW   = 16;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned TotalW   = 17;
  localparam int unsigned CountW   = 6;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

endpackage

`default_nettype wire

/* rtl/ise_cell.sv */
`default_nettype none

module ise_cell #(
  parameter int unsigned IndexBits = 16,
  parameter int unsigned PtrBits   = 6,
  parameter int unsigned CellIdx   = 0
) (
  input  logic                 clk_i,
  input  ise_pkg::cell_ctrl_t  ctrl_i,
  input  logic [PtrBits-1:0]   wr_ptr_i,
  input  logic [IndexBits-1:0] push_lo_i,
  input  logic [IndexBits-1:0] push_hi_i,
  input  logic [IndexBits-1:0] next_lo_i,
  input  logic [IndexBits-1:0] next_hi_i,
  output logic [IndexBits-1:0] lo_o,
  output logic [IndexBits-1:0] hi_o
);
  import ise_pkg::*;

  logic [IndexBits-1:0] lo_q, lo_d;
  logic [IndexBits-1:0] hi_q, hi_d;

  // load a pushed interval at our slot, else take the neighbor's on a pop
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (ctrl_i.push && (wr_ptr_i == PtrBits'(CellIdx))) begin
      lo_d = push_lo_i;
      hi_d = push_hi_i;
    end else if (ctrl_i.pop) begin
      lo_d = next_lo_i;
      hi_d = next_hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

`default_nettype wire

/* rtl/interval_set_engine.sv */
// flow: query, insert, count and well-formed select, deselect and remove requests
//   walk the table in ST_RUN, with one extra put when an interval is split or a select
//   lands before an interval or at the end; unused, clear and reversed-span select,
//   deselect and remove requests go straight from ST_IDLE to ST_DONE
// throughput: one item at a time, set by the single put unit behind cell 0
// reset: asynchronous, active low; the table is empty, no result pending
`default_nettype none

module interval_set_engine #(
  parameter int unsigned MAX_INTERVALS = 32,
  parameter int unsigned INDEX_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // range_start[15:0], range_end[31:16], gap_count[47:32]
  input  logic [ise_pkg::InDataW-1:0]   s_axis_tdata,
  // mode[2:0]
  input  logic [ise_pkg::ModeW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit[0], changed[1], selected_total[18:2], interval_count[24:19],
  // overflow[25], zero[31:26]
  output logic [ise_pkg::OutDataW-1:0]  m_axis_tdata
);
  import ise_pkg::*;

  localparam int unsigned IB  = INDEX_BITS;
  localparam int unsigned OW  = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned CW  = (IB > FieldW) ? IB : FieldW;
  localparam int unsigned SW  = CW + 1;
  localparam int unsigned LW  = IB + 1;
  localparam int unsigned TW  = ((LW > TotalW) ? LW : TotalW) + 1;
  localparam int unsigned XW  = (OW > CountW) ? OW : CountW;
  localparam logic [IB-1:0] TOP = {IB{1'b1}};

  // ------------------------------------------------------------------
  // registers
  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [IB-1:0]    f_q, f_d, l_q, l_d;
  logic [FieldW-1:0] gap_q, gap_d;
  logic             span_ok_q, span_ok_d;
  logic [OW-1:0]    occ_q, occ_d;
  logic [OW-1:0]    rem_q, rem_d;
  logic [OW-1:0]    dcnt_q, dcnt_d;
  logic             tail_v_q, tail_v_d;
  logic [IB-1:0]    tail_lo_q, tail_lo_d, tail_hi_q, tail_hi_d;
  logic             pend_v_q, pend_v_d;
  logic [IB-1:0]    pend_lo_q, pend_lo_d, pend_hi_q, pend_hi_d;
  logic             placed_q, placed_d;
  logic             ovf_q, ovf_d;
  logic             hit_q, hit_d;
  logic             chg_q, chg_d;
  logic [TotalW-1:0] total_q, total_d;
  logic             m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  // ------------------------------------------------------------------
  // chain of cells
  cell_ctrl_t       ctrl;
  logic [OW-1:0]    wr_ptr;
  logic [IB-1:0]    cell_lo [MAX_INTERVALS];
  logic [IB-1:0]    cell_hi [MAX_INTERVALS];
  logic [IB-1:0]    nxt_lo  [MAX_INTERVALS];
  logic [IB-1:0]    nxt_hi  [MAX_INTERVALS];

  for (genvar gi = 0; gi < MAX_INTERVALS; gi++) begin : g_cell
    if (gi == MAX_INTERVALS - 1) begin : g_last
      assign nxt_lo[gi] = '0;
      assign nxt_hi[gi] = '0;
    end else begin : g_mid
      assign nxt_lo[gi] = cell_lo[gi+1];
      assign nxt_hi[gi] = cell_hi[gi+1];
    end
    ise_cell #(
      .IndexBits (IB),
      .PtrBits   (OW),
      .CellIdx   (gi)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .wr_ptr_i  (wr_ptr),
      .push_lo_i (tail_lo_q),
      .push_hi_i (tail_hi_q),
      .next_lo_i (nxt_lo[gi]),
      .next_hi_i (nxt_hi[gi]),
      .lo_o      (cell_lo[gi]),
      .hi_o      (cell_hi[gi])
    );
  end

  // ------------------------------------------------------------------
  // input decode with saturation to the top index
  logic [CW-1:0] in_f_w, in_l_w;
  logic [IB-1:0] in_f, in_l;
  mode_e         in_mode;
  logic          in_pass;
  logic          s_acc;

  assign in_f_w  = CW'(s_axis_tdata[FieldW-1:0]);
  assign in_l_w  = CW'(s_axis_tdata[2*FieldW-1:FieldW]);
  assign in_f    = (in_f_w > CW'(TOP)) ? TOP : in_f_w[IB-1:0];
  assign in_l    = (in_l_w > CW'(TOP)) ? TOP : in_l_w[IB-1:0];
  assign in_mode = mode_e'(s_axis_tuser);
  assign s_acc   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    unique case (in_mode) inside
      MODE_SELECT, MODE_DESELECT, MODE_REMOVE: in_pass = (in_f <= in_l);
      MODE_QUERY, MODE_INSERT, MODE_COUNT:     in_pass = 1'b1;
      default:                                 in_pass = 1'b0;
    endcase
  end

  // ------------------------------------------------------------------
  // rewrite of the interval leaving cell 0 into at most two puts
  logic [IB-1:0] e_lo, e_hi;
  logic          a_v, b_v, ent_ovf, ent_place;
  logic [IB-1:0] a_lo, a_hi, b_lo, b_hi;
  logic          x_v, y_v;
  logic [IB-1:0] y_lo, y_hi;
  logic [LW-1:0] rm_cnt;
  logic [IB-1:0] sh_base;
  logic [SW-1:0] sh_lo, sh_hi;
  logic          sh_drop, sh_clip;
  logic [IB-1:0] sh_hi_c;
  logic [LW-1:0] ent_len;
  logic [TW-1:0] total_sum;

  assign e_lo = cell_lo[0];
  assign e_hi = cell_hi[0];

  // shifter for insert gap, clipped at the top index
  assign sh_base = (e_lo < f_q) ? f_q : e_lo;
  assign sh_lo   = SW'(sh_base) + SW'(gap_q);
  assign sh_hi   = SW'(e_hi) + SW'(gap_q);
  assign sh_drop = sh_lo > SW'(TOP);
  assign sh_clip = sh_hi > SW'(TOP);
  assign sh_hi_c = sh_clip ? TOP : sh_hi[IB-1:0];

  assign rm_cnt  = {1'b0, l_q} - {1'b0, f_q} + LW'(1);
  assign ent_len = {1'b0, e_hi} - {1'b0, e_lo} + LW'(1);
  assign total_sum = TW'(total_q) + TW'(ent_len);

  always_comb begin
    a_v       = 1'b1;
    a_lo      = e_lo;
    a_hi      = e_hi;
    b_v       = 1'b0;
    b_lo      = e_lo;
    b_hi      = e_hi;
    ent_ovf   = 1'b0;
    ent_place = 1'b0;
    x_v       = (e_lo < f_q);
    y_v       = (e_hi > l_q);
    y_lo      = l_q + IB'(1);
    y_hi      = e_hi;
    case (mode_q)
      MODE_SELECT: begin
        if (!placed_q && (e_lo > f_q)) begin
          a_lo      = f_q;
          a_hi      = l_q;
          b_v       = 1'b1;
          ent_place = 1'b1;
        end
      end
      MODE_DESELECT, MODE_REMOVE: begin
        if (mode_q == MODE_REMOVE) begin
          y_lo = f_q;
          y_hi = IB'({1'b0, e_hi} - rm_cnt);
        end
        if ((mode_q == MODE_REMOVE) && (e_lo > l_q)) begin
          // interval past the span slides down
          a_lo = IB'({1'b0, e_lo} - rm_cnt);
          a_hi = IB'({1'b0, e_hi} - rm_cnt);
        end else if (!(e_hi < f_q) && !(e_lo > l_q)) begin
          // overlap: keep the part below and the part above the span
          a_v  = x_v || y_v;
          a_lo = x_v ? e_lo : y_lo;
          a_hi = x_v ? (f_q - IB'(1)) : y_hi;
          b_v  = x_v && y_v;
          b_lo = y_lo;
          b_hi = y_hi;
        end
      end
      MODE_INSERT: begin
        if (!(e_hi < f_q)) begin
          ent_ovf = sh_drop || sh_clip;
          if (e_lo < f_q) begin
            a_hi = f_q - IB'(1);
            b_v  = !sh_drop;
            b_lo = sh_lo[IB-1:0];
            b_hi = sh_hi_c;
          end else begin
            a_v  = !sh_drop;
            a_lo = sh_lo[IB-1:0];
            a_hi = sh_hi_c;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // sequencer and put unit
  logic          put_v;
  logic [IB-1:0] put_lo, put_hi;
  logic          merge;

  assign merge = tail_v_q && (({1'b0, tail_hi_q} + LW'(1)) >= {1'b0, put_lo});
  assign wr_ptr = occ_q - OW'(ctrl.pop);
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    f_d       = f_q;
    l_d       = l_q;
    gap_d     = gap_q;
    span_ok_d = span_ok_q;
    rem_d     = rem_q;
    dcnt_d    = dcnt_q;
    tail_v_d  = tail_v_q;
    tail_lo_d = tail_lo_q;
    tail_hi_d = tail_hi_q;
    pend_v_d  = pend_v_q;
    pend_lo_d = pend_lo_q;
    pend_hi_d = pend_hi_q;
    placed_d  = placed_q;
    ovf_d     = ovf_q;
    hit_d     = hit_q;
    chg_d     = chg_q;
    total_d   = total_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    ctrl      = '0;
    put_v     = 1'b0;
    put_lo    = pend_lo_q;
    put_hi    = pend_hi_q;
    occ_d     = occ_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          mode_d    = in_mode;
          f_d       = in_f;
          l_d       = in_l;
          gap_d     = s_axis_tdata[3*FieldW-1:2*FieldW];
          span_ok_d = (in_f <= in_l);
          rem_d     = occ_q;
          dcnt_d    = '0;
          tail_v_d  = 1'b0;
          pend_v_d  = 1'b0;
          placed_d  = 1'b0;
          ovf_d     = 1'b0;
          hit_d     = 1'b0;
          chg_d     = 1'b0;
          total_d   = '0;
          if (in_mode == MODE_CLEAR) begin
            occ_d = '0;
          end
          state_d = in_pass ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (pend_v_q) begin
          // second put of a split interval, or of the interval behind a placed select span
          put_v    = 1'b1;
          pend_v_d = 1'b0;
        end else if (rem_q != '0) begin
          // take the interval at cell 0
          ctrl.pop  = 1'b1;
          rem_d     = rem_q - OW'(1);
          put_v     = a_v;
          put_lo    = a_lo;
          put_hi    = a_hi;
          pend_v_d  = b_v;
          pend_lo_d = b_lo;
          pend_hi_d = b_hi;
          placed_d  = placed_q || ent_place;
          ovf_d     = ovf_q || ent_ovf;
          hit_d     = hit_q || ((e_lo <= f_q) && (e_hi >= l_q));
          chg_d     = chg_q || (e_hi >= f_q);
          total_d   = (total_sum > TW'({TotalW{1'b1}})) ? {TotalW{1'b1}}
                                                         : total_sum[TotalW-1:0];
        end else if ((mode_q == MODE_SELECT) && !placed_q) begin
          // new span lies after every stored interval
          put_v    = 1'b1;
          put_lo   = f_q;
          put_hi   = l_q;
          placed_d = 1'b1;
        end else begin
          // flush the open interval into the chain
          ctrl.push = tail_v_q;
          tail_v_d  = 1'b0;
          state_d   = ST_DONE;
        end

        if (put_v) begin
          if (merge) begin
            tail_hi_d = (put_hi > tail_hi_q) ? put_hi : tail_hi_q;
          end else if (dcnt_q == OW'(MAX_INTERVALS)) begin
            ovf_d = 1'b1;
          end else begin
            ctrl.push = tail_v_q;
            tail_v_d  = 1'b1;
            tail_lo_d = put_lo;
            tail_hi_d = put_hi;
            dcnt_d    = dcnt_q + OW'(1);
          end
        end
        occ_d = occ_q - OW'(ctrl.pop) + OW'(ctrl.push);
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          m_data_d[0] = (mode_q == MODE_QUERY) && span_ok_q && hit_q;
          m_data_d[1] = ((mode_q == MODE_INSERT) && (gap_q != '0) && chg_q)
                        || ((mode_q == MODE_REMOVE) && chg_q);
          m_data_d[TotalW+1:2] = (mode_q == MODE_COUNT) ? total_q : '0;
          m_data_d[TotalW+CountW+1:TotalW+2] =
              (XW'(occ_q) > XW'({CountW{1'b1}})) ? {CountW{1'b1}}
                                                  : CountW'(occ_q);
          m_data_d[TotalW+CountW+2] = ovf_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      occ_q     <= '0;
      m_valid_q <= 1'b0;
      rem_q     <= '0;
      pend_v_q  <= 1'b0;
      tail_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      m_valid_q <= m_valid_d;
      rem_q     <= rem_d;
      pend_v_q  <= pend_v_d;
      tail_v_q  <= tail_v_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    f_q       <= f_d;
    l_q       <= l_d;
    gap_q     <= gap_d;
    span_ok_q <= span_ok_d;
    dcnt_q    <= dcnt_d;
    tail_lo_q <= tail_lo_d;
    tail_hi_q <= tail_hi_d;
    pend_lo_q <= pend_lo_d;
    pend_hi_q <= pend_hi_d;
    placed_q  <= placed_d;
    ovf_q     <= ovf_d;
    hit_q     <= hit_d;
    chg_q     <= chg_d;
    total_q   <= total_d;
    m_data_q  <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ------------------------------------------------------------------
  // checks
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(MAX_INTERVALS))
    else $error("chain holds more intervals than cells");

  a_push_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |-> (wr_ptr < OW'(MAX_INTERVALS)))
    else $error("push beyond the last cell");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && (in_mode == MODE_CLEAR)) |=> (occ_q == '0))
    else $error("clear left intervals in the chain");

endmodule

`default_nettype wire

/* dv/tb_interval_set_engine.sv */
`default_nettype none

module tb_interval_set_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import ise_pkg::*;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned TopIndex   = 65535;
  localparam int unsigned RandItems  = 1600;
  localparam int unsigned DirItems   = 22;

  // packed from the top bit down, so hit lands in bit 0
  typedef struct packed {
    logic        ovf;
    logic [5:0]  count;
    logic [16:0] total;
    logic        changed;
    logic        hit;
  } set_result_t;

  typedef struct {
    mode_e       mode;
    int unsigned first;
    int unsigned last;
    int unsigned gap;
    logic        typed;   // row carries a typed-in result
    set_result_t want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  interval_set_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor copy of the interval table
  int unsigned span_lo [TableDepth];
  int unsigned span_hi [TableDepth];
  int unsigned span_n;
  int unsigned work_lo [TableDepth];
  int unsigned work_hi [TableDepth];
  int unsigned work_n;
  logic        work_ovf;

  set_result_t pending_q[$];
  int          err_cnt;
  int          result_cnt;
  int          sent_cnt;
  int unsigned mode_seen [8];

  // append in order, merging touching intervals
  function automatic void work_put(int unsigned lo, int unsigned hi);
    if (work_n > 0 && work_hi[work_n-1] + 1 >= lo) begin
      if (hi > work_hi[work_n-1]) work_hi[work_n-1] = hi;
      return;
    end
    if (work_n >= TableDepth) begin
      work_ovf = 1'b1;
      return;
    end
    work_lo[work_n] = lo;
    work_hi[work_n] = hi;
    work_n++;
  endfunction

  function automatic void work_put_shifted(int unsigned lo, int unsigned hi);
    if (lo > TopIndex) begin
      work_ovf = 1'b1;
      return;
    end
    if (hi > TopIndex) begin
      hi = TopIndex;
      work_ovf = 1'b1;
    end
    work_put(lo, hi);
  endfunction

  function automatic void work_commit();
    for (int i = 0; i < work_n; i++) begin
      span_lo[i] = work_lo[i];
      span_hi[i] = work_hi[i];
    end
    span_n = work_n;
  endfunction

  // compute the result of one request and update the table copy
  function automatic set_result_t apply_request(mode_e mode, int unsigned f,
                                                int unsigned l, int unsigned gap);
    set_result_t r;
    logic        placed;
    longint unsigned sum;
    int unsigned cnt;
    r = '0;
    sum = 0;
    work_n = 0;
    work_ovf = 1'b0;
    case (mode)
      MODE_SELECT: begin
        if (f <= l) begin
          placed = 1'b0;
          for (int i = 0; i < span_n; i++) begin
            if (!placed && span_lo[i] > f) begin
              work_put(f, l);
              placed = 1'b1;
            end
            work_put(span_lo[i], span_hi[i]);
          end
          if (!placed) work_put(f, l);
          work_commit();
        end
      end
      MODE_DESELECT: begin
        if (f <= l) begin
          for (int i = 0; i < span_n; i++) begin
            if (span_hi[i] < f || span_lo[i] > l) begin
              work_put(span_lo[i], span_hi[i]);
            end else begin
              if (span_lo[i] < f) work_put(span_lo[i], f - 1);
              if (span_hi[i] > l) work_put(l + 1, span_hi[i]);
            end
          end
          work_commit();
        end
      end
      MODE_QUERY: begin
        if (f <= l)
          for (int i = 0; i < span_n; i++)
            if (span_lo[i] <= f && span_hi[i] >= l) r.hit = 1'b1;
      end
      MODE_INSERT: begin
        if (gap != 0 && span_n > 0 && span_hi[span_n-1] >= f) begin
          r.changed = 1'b1;
          for (int i = 0; i < span_n; i++) begin
            if (span_hi[i] < f) begin
              work_put(span_lo[i], span_hi[i]);
            end else if (span_lo[i] < f) begin
              work_put(span_lo[i], f - 1);
              work_put_shifted(f + gap, span_hi[i] + gap);
            end else begin
              work_put_shifted(span_lo[i] + gap, span_hi[i] + gap);
            end
          end
          work_commit();
        end
      end
      MODE_REMOVE: begin
        if (f <= l && span_n > 0 && span_hi[span_n-1] >= f) begin
          cnt = l - f + 1;
          r.changed = 1'b1;
          for (int i = 0; i < span_n; i++) begin
            if (span_hi[i] < f) begin
              work_put(span_lo[i], span_hi[i]);
            end else if (span_lo[i] > l) begin
              work_put(span_lo[i] - cnt, span_hi[i] - cnt);
            end else begin
              if (span_lo[i] < f) work_put(span_lo[i], f - 1);
              if (span_hi[i] > l) work_put(f, span_hi[i] - cnt);
            end
          end
          work_commit();
        end
      end
      MODE_COUNT: begin
        for (int i = 0; i < span_n; i++) sum += span_hi[i] - span_lo[i] + 1;
        r.total = (sum > 17'h1FFFF) ? 17'h1FFFF : sum[16:0];
      end
      MODE_CLEAR: span_n = 0;
      default: ;
    endcase
    r.count = span_n[5:0];
    r.ovf = work_ovf;
    return r;
  endfunction

  // clock and reset
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // random gap, mostly short with an occasional long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one request and queue its expected result
  task automatic send_request(mode_e mode, int unsigned f, int unsigned l,
                              int unsigned gap, logic typed, set_result_t want);
    set_result_t pred;
    int unsigned idle;
    idle = pick_gap();
    if (idle != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {gap[15:0], l[15:0], f[15:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = apply_request(mode, f, l, gap);
    if (typed && pred !== want) begin
      $error("typed row disagrees with prediction: mode %s", mode.name());
      err_cnt++;
    end
    pending_q.insert(pending_q.size(), typed ? want : pred);
    mode_seen[mode]++;
    sent_cnt++;
  endtask

  function automatic set_result_t res(logic hit, logic chg, int unsigned tot,
                                      int unsigned cnt, logic ovf);
    set_result_t r;
    r.hit = hit;
    r.changed = chg;
    r.total = tot[16:0];
    r.count = cnt[5:0];
    r.ovf = ovf;
    return r;
  endfunction

  // random index near an edge or anywhere
  function automatic int unsigned rand_index();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 300);
      1: return $urandom_range(TopIndex - 300, TopIndex);
      default: return $urandom_range(0, TopIndex);
    endcase
  endfunction

  // stimulus
  initial begin
    dir_row_t    rows [DirItems];
    int unsigned f;
    int unsigned l;
    int unsigned g;
    int unsigned ext;
    int unsigned roll;
    mode_e       m;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_SELECT;
    span_n = 0;
    err_cnt = 0;
    sent_cnt = 0;

    rows = '{
      '{MODE_COUNT,    0, 0, 0, 1'b1, res(0, 0, 0, 0, 0)},
      '{MODE_QUERY,    0, 0, 0, 1'b1, res(0, 0, 0, 0, 0)},
      '{MODE_INSERT,   0, 0, 5, 1'b1, res(0, 0, 0, 0, 0)},
      '{MODE_REMOVE,   0, 9, 0, 1'b1, res(0, 0, 0, 0, 0)},
      '{MODE_SELECT,   0, TopIndex, 0, 1'b1, res(0, 0, 0, 1, 0)},
      '{MODE_COUNT,    0, 0, 0, 1'b1, res(0, 0, 65536, 1, 0)},
      '{MODE_QUERY,    0, TopIndex, 0, 1'b1, res(1, 0, 0, 1, 0)},
      '{MODE_CLEAR,    0, 0, 0, 1'b1, res(0, 0, 0, 0, 0)},
      '{MODE_SELECT,   10, 20, 0, 1'b0, '0},
      '{MODE_SELECT,   21, 30, 0, 1'b0, '0},
      '{MODE_SELECT,   50, 40, 0, 1'b0, '0},
      '{MODE_SELECT,   100, 200, 0, 1'b0, '0},
      '{MODE_DESELECT, 15, 16, 0, 1'b0, '0},
      '{MODE_UNUSED,   TopIndex, TopIndex, TopIndex, 1'b0, '0},
      '{MODE_QUERY,    17, 17, 0, 1'b0, '0},
      '{MODE_QUERY,    20, 10, 0, 1'b0, '0},
      '{MODE_INSERT,   18, 0, 0, 1'b0, '0},
      '{MODE_INSERT,   18, 0, 65535, 1'b0, '0},
      '{MODE_SELECT,   60000, TopIndex, 0, 1'b0, '0},
      '{MODE_INSERT,   5, 0, 2000, 1'b0, '0},
      '{MODE_REMOVE,   31, 99, 0, 1'b0, '0},
      '{MODE_DESELECT, 0, TopIndex, 0, 1'b0, '0}
    };

    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (rows[i])
      send_request(rows[i].mode, rows[i].first, rows[i].last, rows[i].gap,
                   rows[i].typed, rows[i].want);

    // fill the table past its depth with one-index spans
    for (int i = 0; i < 36; i++)
      send_request(MODE_SELECT, 1000 + 3 * i, 1000 + 3 * i, 0, 1'b0, '0);

    for (int i = 0; i < RandItems; i++) begin
      // hold off until every result is back
      if (i == RandItems / 2) begin
        s_axis_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk_i);
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) m = MODE_SELECT;
      else if (roll < 55) m = MODE_DESELECT;
      else if (roll < 68) m = MODE_QUERY;
      else if (roll < 78) m = MODE_INSERT;
      else if (roll < 88) m = MODE_REMOVE;
      else if (roll < 94) m = MODE_COUNT;
      else if (roll < 97) m = MODE_UNUSED;
      else m = MODE_CLEAR;
      f = rand_index();
      case ($urandom_range(0, 9))
        0: l = rand_index();
        1: l = (f > 0) ? f - 1 : 0;
        default: begin
          ext = $urandom_range(0, 400);
          l = (f + ext > TopIndex) ? TopIndex : f + ext;
        end
      endcase
      case ($urandom_range(0, 5))
        0: g = 0;
        1: g = $urandom_range(0, TopIndex);
        default: g = $urandom_range(1, 500);
      endcase
      send_request(m, f, l, g, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (80) @(posedge clk_i);
    $display("covered %0d requests, %0d results checked", sent_cnt, result_cnt);
    $display("mode counts: sel %0d desel %0d qry %0d ins %0d rem %0d cnt %0d",
             mode_seen[0], mode_seen[1], mode_seen[3], mode_seen[4],
             mode_seen[5], mode_seen[6]);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side with random stalls
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall != 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        stall = pick_gap();
        m_axis_tready <= (stall == 0);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    set_result_t want;
    set_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[25:0];
      result_cnt++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d actual %0d", want.hit, got.hit);
          err_cnt++;
        end
        if (got.changed !== want.changed) begin
          $error("changed: expected %0d actual %0d", want.changed, got.changed);
          err_cnt++;
        end
        if (got.total !== want.total) begin
          $error("selected_total: expected %0d actual %0d", want.total, got.total);
          err_cnt++;
        end
        if (got.count !== want.count) begin
          $error("interval_count: expected %0d actual %0d", want.count, got.count);
          err_cnt++;
        end
        if (got.ovf !== want.ovf) begin
          $error("overflow: expected %0d actual %0d", want.ovf, got.ovf);
          err_cnt++;
        end
        if (m_axis_tdata[31:26] !== '0) begin
          $error("pad bits: expected 0 actual %h", m_axis_tdata[31:26]);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #4ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
